// ===== sv/mcps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcps_pkg: shared types and constants of the period scheduler
// Field widths, register map and the per-channel status group.
// ----------------------------------------------------------------------------
package mcps_pkg;

  // fixed field widths of the item channels
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned PERIOD_W  = 16;

  // register map: one period register per channel, 32-bit words
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_PERIOD_CH0 = 3'd0;

  // status of one channel for the current beat
  typedef struct packed {
    logic enabled;
    logic due;
  } chan_stat_t;

endpackage
`default_nettype wire

// ===== sv/mcps_chan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcps_chan: one scheduler channel
// Holds the remaining time and, on a step while enabled, takes off elapsed time
// or reloads the period when the elapsed time reaches it (the channel falls due).
// ----------------------------------------------------------------------------
module mcps_chan #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire logic [mcps_pkg::PERIOD_W-1:0]   period,
  input  wire logic [mcps_pkg::ELAPSED_W-1:0]  elapsed,
  output      logic [TIME_BITS-1:0]            time_next,
  output      mcps_pkg::chan_stat_t            stat
);

  // compare width wide enough for both the time state and the elapsed field
  localparam int unsigned W = (TIME_BITS > mcps_pkg::ELAPSED_W) ?
                              TIME_BITS : mcps_pkg::ELAPSED_W;

  logic [TIME_BITS-1:0] time_left_r;
  logic [TIME_BITS-1:0] time_left_nxt;
  logic [W-1:0]         t_ext;
  logic [W-1:0]         e_ext;
  logic [W-1:0]         p_ext;
  logic [W-1:0]         tmax_ext;
  logic [W-1:0]         diff;
  logic [TIME_BITS-1:0] reload;
  logic                 enabled;
  logic                 expired;

  assign enabled  = (period != '0);
  assign t_ext    = W'(time_left_r);
  assign e_ext    = W'(elapsed);
  assign p_ext    = W'(period);
  assign tmax_ext = W'({TIME_BITS{1'b1}});
  assign expired  = (e_ext >= t_ext);
  assign diff     = t_ext - e_ext;

  // clamp the period to what the time state can hold
  assign reload = (p_ext > tmax_ext) ? {TIME_BITS{1'b1}} : TIME_BITS'(p_ext);

  always_comb begin
    if (!enabled) begin
      time_next = time_left_r;
    end else if (expired) begin
      time_next = reload;
    end else begin
      time_next = TIME_BITS'(diff);
    end
  end

  assign time_left_nxt = step ? time_next : time_left_r;

  assign stat.enabled = enabled;
  assign stat.due     = enabled & expired;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_left_r <= '0;
    end else begin
      time_left_r <= time_left_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/multi_channel_period_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_period_scheduler: periodic timer over up to eight channels
// Each input beat carries elapsed milliseconds; each result beat carries the
// due mask, the shortest remaining wait and a none-enabled flag.
// ----------------------------------------------------------------------------
// The block accepts one elapsed-time beat per clock while the result side
// is not stalled and returns one result beat per input beat, in order. From
// the input register all channels update in parallel (subtract or reload)
// and a three-level min tree over the channels finds the shortest wait; the
// result is then held in the output register, and sustained throughput is
// one beat per cycle when out_ready stays high. A stall on the result side
// holds the output register, then the input register, and in_ready drops
// only when both are full. Periods are written over the APB-style port
// (register i at byte address 4*i, zero disables a channel); the user must
// write them only while no beat is in flight, which the block does not
// enforce. A channel is due on its first beat after enabling from reset.
// ----------------------------------------------------------------------------
module multi_channel_period_scheduler #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input beats
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [mcps_pkg::ELAPSED_W-1:0]  in_elapsed_ms,
  // result beats
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [mcps_pkg::MASK_W-1:0]     out_due_mask,
  output      logic [mcps_pkg::WAIT_W-1:0]     out_next_wait_ms,
  output      logic                            out_none_enabled,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mcps_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [mcps_pkg::DATA_W-1:0]     pwdata,
  output      logic [mcps_pkg::DATA_W-1:0]     prdata,
  output      logic                            pready
);

  localparam int unsigned W = (TIME_BITS > mcps_pkg::WAIT_W) ?
                              TIME_BITS : mcps_pkg::WAIT_W;

  // ---------------------------------------------------------------- config
  logic [mcps_pkg::PERIOD_W-1:0] period_r [CHANNELS];
  logic [mcps_pkg::IDX_W-1:0]    cfg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[mcps_pkg::ADDR_W-1:2] - mcps_pkg::REG_PERIOD_CH0;
  assign cfg_wr  = psel & penable & pwrite & pready;

  // registers beyond CHANNELS match no entry: writes drop, reads give zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        period_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (cfg_idx == mcps_pkg::IDX_W'(i)) begin
          period_r[i] <= pwdata[mcps_pkg::PERIOD_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (cfg_idx == mcps_pkg::IDX_W'(i)) begin
        prdata = mcps_pkg::DATA_W'(period_r[i]);
      end
    end
  end

  // ---------------------------------------------------------- beat control
  logic                           s1_valid_r;
  logic                           s1_valid_nxt;
  logic [mcps_pkg::ELAPSED_W-1:0] s1_elapsed_r;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           advance;
  logic                           step;

  // advance the input register whenever the output register is free or drains
  assign advance  = ~out_valid_r | out_ready;
  assign in_ready = ~s1_valid_r | advance;
  assign step     = s1_valid_r & advance;

  assign s1_valid_nxt  = (in_valid & in_ready) | (s1_valid_r & ~advance);
  assign out_valid_nxt = step | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_elapsed_r <= in_elapsed_ms;
    end
  end

  // -------------------------------------------------------------- channels
  logic [TIME_BITS-1:0]    time_next [CHANNELS];
  mcps_pkg::chan_stat_t    stat      [CHANNELS];

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    mcps_chan #(
      .TIME_BITS (TIME_BITS)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .period    (period_r[g]),
      .elapsed   (s1_elapsed_r),
      .time_next (time_next[g]),
      .stat      (stat[g])
    );
  end

  // ------------------------------------------------------- due mask and min
  logic [mcps_pkg::MASK_W-1:0] due_mask;
  logic [TIME_BITS-1:0]        leaf  [mcps_pkg::MASK_W];
  logic [TIME_BITS-1:0]        min_a [4];
  logic [TIME_BITS-1:0]        min_b [2];
  logic [TIME_BITS-1:0]        best;
  logic [W-1:0]                best_ext;
  logic                        any_en;

  // eight leaves; disabled and absent channels enter at the largest time
  for (genvar g = 0; g < mcps_pkg::MASK_W; g++) begin : g_leaf
    if (g < CHANNELS) begin : g_used
      assign leaf[g] = stat[g].enabled ? time_next[g] : '1;
    end else begin : g_pad
      assign leaf[g] = '1;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_min_a
    assign min_a[g] = (leaf[2*g+1] < leaf[2*g]) ? leaf[2*g+1] : leaf[2*g];
  end

  for (genvar g = 0; g < 2; g++) begin : g_min_b
    assign min_b[g] = (min_a[2*g+1] < min_a[2*g]) ? min_a[2*g+1] : min_a[2*g];
  end

  assign best = (min_b[1] < min_b[0]) ? min_b[1] : min_b[0];

  always_comb begin
    due_mask = '0;
    any_en   = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      due_mask[i] = stat[i].due;
      any_en      = any_en | stat[i].enabled;
    end
  end

  // report the low wait bits; zero when nothing is enabled
  assign best_ext = any_en ? W'(best) : '0;

  // -------------------------------------------------------- result register
  logic [mcps_pkg::MASK_W-1:0] out_due_mask_r;
  logic [mcps_pkg::WAIT_W-1:0] out_next_wait_r;
  logic                        out_none_r;

  always_ff @(posedge clk) begin
    if (step) begin
      out_due_mask_r  <= due_mask;
      out_next_wait_r <= best_ext[mcps_pkg::WAIT_W-1:0];
      out_none_r      <= ~any_en;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_due_mask     = out_due_mask_r;
  assign out_next_wait_ms = out_next_wait_r;
  assign out_none_enabled = out_none_r;

  // ------------------------------------------------------------ assertions
  // an idle schedule reports neither due channels nor a wait
  a_none_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_enabled) |-> (out_due_mask == '0 && out_next_wait_ms == '0))
    else $error("none_enabled result carries a due mask or a wait");

  // channels beyond CHANNELS never show up as due
  a_mask_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_due_mask >> CHANNELS) == '0))
    else $error("due bit set for a channel that does not exist");

  // with both registers full and the result stalled, take no new beat
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are stalled");

  // an accepted beat is held in the input register on the next cycle
  a_capture : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted beat lost");

endmodule
`default_nettype wire
